// ===== src/kes_pkg.sv =====
// Shared types, constants and table-building functions of the keyframe easing sampler.
`default_nettype none
package kes_pkg;

    localparam int MAX_KEYS_DEF    = 64;
    localparam int EASE_POINTS_DEF = 257;
    localparam int APB_AW          = 5;
    localparam int DIV_NW          = 40;
    localparam int DIV_DW          = 24;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic [2:0] EASE_STEP   = 3'd0;
    localparam logic [2:0] EASE_LINEAR = 3'd1;
    localparam logic [2:0] EASE_IN     = 3'd2;
    localparam logic [2:0] EASE_OUT    = 3'd3;
    localparam logic [2:0] EASE_INOUT  = 3'd4;
    localparam logic [2:0] EASE_SMOOTH = 3'd5;
    localparam logic [2:0] EASE_EXP    = 3'd6;
    localparam logic [2:0] EASE_LOG    = 3'd7;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_LOOP   = 3'd1;
    localparam logic [2:0] REG_SPEED  = 3'd2;
    localparam logic [2:0] REG_CLIP   = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;

    localparam logic [15:0] SPEED_RST = 16'd256;
    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         key_index;
        logic [23:0]        key_time;
        logic signed [31:0] key_value;
        logic [2:0]         key_easing;
        logic [23:0]        step_time;
    } req_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [23:0]        playhead;
        logic               still_playing;
    } res_t;

    typedef struct packed {
        logic [23:0]        key_time;
        logic signed [31:0] key_value;
        logic [2:0]         key_easing;
    } key_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    // Unsigned 64-bit quotient by shift and subtract, used only at elaboration
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] part;
        logic [63:0] quo;
        part = '0;
        quo  = '0;
        for (int b = 63; b >= 0; b--) begin
            part = {part[63:0], num[b]};
            if (part >= {1'b0, den}) begin
                part   = part - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^x - 1 in Q30 for x in Q30, series evaluated at elaboration
    function automatic logic [63:0] em1_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        term = Q30_ONE;
        sum  = 64'd0;
        for (int n = 1; n <= 24; n++) begin
            term = udiv64((term * x) >> 30, 64'(n));
            sum  = sum + term;
        end
        return sum;
    endfunction

    localparam logic [63:0] EM1_Q30 = em1_q30(Q30_ONE);

    // One entry of the exp or log curve table, Q1.16 with 1.0 as 65536
    function automatic logic [16:0] ease_entry(input int k, input int last, input logic is_log);
        logic [63:0] em1;
        logic [63:0] x;
        logic [63:0] ev;
        logic [63:0] r;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] s;
        em1 = EM1_Q30;
        x   = udiv64(64'(k) << 30, 64'(last));
        if (!is_log) begin
            ev = em1_q30(x);
            r  = udiv64((ev << 16) + (em1 >> 1), em1);
        end
        else begin
            y  = Q30_ONE + ((x * em1) >> 30);
            z  = udiv64((y - Q30_ONE) << 30, y + Q30_ONE);
            z2 = (z * z) >> 30;
            pw = z;
            s  = 64'd0;
            for (int n = 0; n < 24; n++) begin
                s  = s + udiv64(pw, 64'(2 * n + 1));
                pw = (pw * z2) >> 30;
            end
            r = (64'd2 * s + (64'd1 << 13)) >> 14;
        end
        if (r > 64'd65536) begin
            r = 64'd65536;
        end
        return r[16:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/kes_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module kes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/kes_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module kes_div
    import kes_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_req_t          req,
    output      logic              done,
    output      logic [DIV_NW-1:0] quot,
    output      logic [DIV_DW-1:0] rem
);
    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] quot_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dsr_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quot_reg[DIV_NW-1]} - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            dsr_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_DW])
            begin
                rem_reg  <= trial[DIV_DW-1:0];
                quot_reg <= {quot_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[DIV_DW-2:0], quot_reg[DIV_NW-1]};
                quot_reg <= {quot_reg[DIV_NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

// ===== src/kes_ease.sv =====
// Easing curve unit: one shared multiplier, exp and log tables.
`default_nettype none
module kes_ease
    import kes_pkg::*;
#(
    parameter int EASE_TABLE_POINTS = EASE_POINTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [16:0] alpha,
    input  wire logic [2:0]  code,
    output      logic        done,
    output      logic [16:0] curve
);
    localparam int LAST = EASE_TABLE_POINTS - 1;
    localparam int TW   = $clog2(EASE_TABLE_POINTS);

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_MUL  = 2'd1;
    localparam logic [1:0] E_EVAL = 2'd2;

    localparam logic [16:0] ONE   = 17'h10000;
    localparam logic [16:0] HALF  = 17'h08000;

    typedef logic [16:0] tab_t [EASE_TABLE_POINTS];

    function automatic tab_t build_tab(input logic is_log);
        tab_t tb;
        for (int k = 0; k < EASE_TABLE_POINTS; k++) begin
            tb[k] = ease_entry(k, LAST, is_log);
        end
        return tb;
    endfunction

    localparam tab_t EXP_TAB = build_tab(1'b0);
    localparam tab_t LOG_TAB = build_tab(1'b1);

    logic [1:0]  st_reg;
    logic [1:0]  st_next;
    logic        phase_reg;
    logic        done_reg;
    logic [16:0] a_reg;
    logic [2:0]  code_reg;
    logic [17:0] opa_reg;
    logic [17:0] opb_reg;
    logic [35:0] mul_reg;
    logic [16:0] lo_reg;
    logic [16:0] curve_reg;

    logic [17:0] u1;
    logic [17:0] u2;
    logic [TW-1:0] idx;
    logic [TW-1:0] idx_hi;
    logic [16:0] tab_lo;
    logic [16:0] tab_hi;
    logic [16:0] tab_end;

    assign u1     = 18'(ONE) - {1'b0, alpha};
    assign u2     = 18'd131072 - {alpha, 1'b0};
    assign idx    = mul_reg[16+TW-1:16];
    assign idx_hi = idx + 1'b1;
    assign tab_lo  = (code_reg == EASE_LOG) ? LOG_TAB[idx] : EXP_TAB[idx];
    assign tab_hi  = (code_reg == EASE_LOG) ? LOG_TAB[idx_hi] : EXP_TAB[idx_hi];
    assign tab_end = (code_reg == EASE_LOG) ? LOG_TAB[LAST] : EXP_TAB[LAST];

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    st_next = E_MUL;
                end
            end
            E_MUL:
            begin
                st_next = E_EVAL;
            end
            E_EVAL:
            begin
                if (!phase_reg && (code_reg == EASE_SMOOTH
                    || ((code_reg == EASE_EXP || code_reg == EASE_LOG)
                        && 32'(idx) < 32'(LAST))))
                begin
                    st_next = E_MUL;
                end
                else
                begin
                    st_next = E_IDLE;
                end
            end
            default:
            begin
                st_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= E_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == E_EVAL) && (st_next == E_IDLE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    a_reg     <= alpha;
                    code_reg  <= code;
                    phase_reg <= 1'b0;
                    case (code)
                        EASE_OUT:
                        begin
                            opa_reg <= u1;
                            opb_reg <= u1;
                        end
                        EASE_INOUT:
                        begin
                            if (alpha < HALF)
                            begin
                                opa_reg <= {1'b0, alpha};
                                opb_reg <= {1'b0, alpha};
                            end
                            else
                            begin
                                opa_reg <= u2;
                                opb_reg <= u2;
                            end
                        end
                        EASE_EXP, EASE_LOG:
                        begin
                            opa_reg <= {1'b0, alpha};
                            opb_reg <= 18'(LAST);
                        end
                        default:
                        begin
                            opa_reg <= {1'b0, alpha};
                            opb_reg <= {1'b0, alpha};
                        end
                    endcase
                end
            end
            E_MUL:
            begin
                mul_reg <= opa_reg * opb_reg;
            end
            E_EVAL:
            begin
                if (phase_reg)
                begin
                    if (code_reg == EASE_SMOOTH)
                    begin
                        curve_reg <= mul_reg[32:16];
                    end
                    else
                    begin
                        curve_reg <= lo_reg + mul_reg[32:16];
                    end
                end
                else
                begin
                    phase_reg <= 1'b1;
                    case (code_reg)
                        EASE_STEP:   curve_reg <= '0;
                        EASE_LINEAR: curve_reg <= a_reg;
                        EASE_IN:     curve_reg <= mul_reg[32:16];
                        EASE_OUT:    curve_reg <= ONE - mul_reg[32:16];
                        EASE_INOUT:
                        begin
                            if (a_reg < HALF)
                            begin
                                curve_reg <= mul_reg[31:15];
                            end
                            else
                            begin
                                curve_reg <= ONE - mul_reg[33:17];
                            end
                        end
                        EASE_SMOOTH:
                        begin
                            opa_reg <= mul_reg[33:16];
                            opb_reg <= 18'd196608 - {a_reg, 1'b0};
                        end
                        default:
                        begin
                            // exp or log: interpolate between two table points
                            if (32'(idx) >= 32'(LAST))
                            begin
                                curve_reg <= tab_end;
                            end
                            else
                            begin
                                lo_reg  <= tab_lo;
                                opa_reg <= (tab_hi < tab_lo) ? '0 : {1'b0, tab_hi - tab_lo};
                                opb_reg <= {2'b00, mul_reg[15:0]};
                            end
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign curve = curve_reg;
endmodule
`default_nettype wire

// ===== src/keyframe_easing_sampler_unit.sv =====
// Top level of the keyframe easing sampler: control sequencer, registers and key store.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  req     | in        | req_valid/req_ready| mode, key slot, key data, step time
//  res     | out       | res_valid/res_ready| sample value, playhead, still playing
//  apb     | in        | psel/penable/pready| registers enable..key_count at 4*i
//
// A key write, a restart or an ignored tick is taken in S_IDLE, which the sequencer
// does not leave. A tick that runs steps through multiply, add, modulo (loop mode
// only), sample, a scan of one key per cycle, the alpha divide (only when blending),
// easing, blend and output; the serial divider and the one-key-per-cycle scan of the
// key RAM make up most of its length.
// Reset clears the control state and registers; the key RAM holds garbage
// until written. A finished result waits in the output register while
// requests are taken; a new result holds the sequencer until that one is taken.
`default_nettype none
module keyframe_easing_sampler_unit
    import kes_pkg::*;
#(
    parameter int MAX_KEYS          = MAX_KEYS_DEF,
    parameter int EASE_TABLE_POINTS = EASE_POINTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output      logic              req_ready,
    input  wire req_t              req,
    output      logic              res_valid,
    input  wire logic              res_ready,
    output      res_t              res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready
);
    localparam int KAW = $clog2(MAX_KEYS);
    localparam int NW  = $clog2(MAX_KEYS + 1);
    localparam int KW  = $bits(key_t);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_ADD    = 4'd2;
    localparam logic [3:0] S_MOD    = 4'd3;
    localparam logic [3:0] S_SAMPLE = 4'd4;
    localparam logic [3:0] S_KEY    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_EASE   = 4'd7;
    localparam logic [3:0] S_BLEND  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    // configuration registers
    logic               enable_reg;
    logic               loop_reg;
    logic signed [15:0] speed_reg;
    logic [23:0]        clip_reg;
    logic [6:0]         count_reg;

    // playback state
    logic [23:0]        play_reg;
    logic               playing_reg;

    // datapath
    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic [23:0]        dt_reg;
    logic signed [40:0] prod_reg;
    logic signed [33:0] t_reg;
    logic [NW-1:0]      idx_reg;
    key_t               prev_reg;
    key_t               cur_reg;
    logic signed [31:0] val_reg;
    logic signed [50:0] blend_reg;
    res_t               res_reg;
    logic               res_valid_reg;

    logic               req_take;
    logic               cfg_write;
    logic               tick_go;
    logic               key_we;
    logic [KAW-1:0]     ram_raddr;
    logic [KW-1:0]      ram_rdata;
    key_t               key;
    logic [NW-1:0]      n_keys;
    logic [NW-1:0]      idx_inc;
    logic signed [33:0] t_sum;
    logic [33:0]        t_abs;
    logic [23:0]        mod_res;
    logic               key_hit;
    logic               span_zero;
    logic [16:0]        alpha;
    logic signed [32:0] diff;
    div_req_t           div_req;
    logic               div_done;
    logic [DIV_NW-1:0]  div_quot;
    logic [DIV_DW-1:0]  div_rem;
    logic               ease_start;
    logic               ease_done;
    logic [16:0]        ease_curve;

    assign req_ready = (state_reg == S_IDLE);
    assign req_take  = req_valid && req_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // a tick is carried out only while enabled, playing and with a clip
    assign tick_go = (req.mode == MODE_TICK) && enable_reg && playing_reg
                     && (clip_reg != '0);
    assign key_we  = req_take && (req.mode == MODE_WRITE)
                     && (32'(req.key_index) < 32'(MAX_KEYS));

    assign n_keys  = (32'(count_reg) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(count_reg);
    assign idx_inc = idx_reg + 1'b1;

    // playhead plus floor(dt * speed / 256)
    assign t_sum   = $signed({10'd0, play_reg}) + $signed({prod_reg[40], prod_reg[40:8]});
    assign t_abs   = t_sum[33] ? 34'(-t_sum) : 34'(t_sum);
    assign mod_res = (t_reg[33] && div_rem != '0) ? clip_reg - div_rem : div_rem;

    assign key       = key_t'(ram_rdata);
    assign key_hit   = (play_reg <= key.key_time);
    assign span_zero = (key.key_time <= prev_reg.key_time);
    assign alpha     = (div_quot > DIV_NW'(65536)) ? 17'h10000 : div_quot[16:0];
    assign diff      = 33'(cur_reg.key_value) - 33'(prev_reg.key_value);

    // read address: slot 0 on entry to the scan, then the slot after the current
    assign ram_raddr = (state_reg == S_SAMPLE) ? '0 : idx_inc[KAW-1:0];

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_NW'(t_abs);
        div_req.divisor  = clip_reg;
        if (state_reg == S_ADD)
        begin
            div_req.start = loop_reg;
        end
        else if (state_reg == S_KEY)
        begin
            div_req.start    = (idx_reg != '0) && key_hit && !span_zero;
            div_req.dividend = {play_reg - prev_reg.key_time, 16'd0};
            div_req.divisor  = key.key_time - prev_reg.key_time;
        end
    end

    assign ease_start = (state_reg == S_DIV) && div_done;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_take && tick_go)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = loop_reg ? S_MOD : S_SAMPLE;
            end
            S_MOD:
            begin
                if (div_done)
                begin
                    state_next = S_SAMPLE;
                end
            end
            S_SAMPLE:
            begin
                state_next = (n_keys == '0) ? S_OUT : S_KEY;
            end
            S_KEY:
            begin
                if (idx_reg == '0)
                begin
                    if (n_keys == NW'(1) || key_hit || idx_inc == n_keys)
                    begin
                        state_next = S_OUT;
                    end
                end
                else if (key_hit)
                begin
                    state_next = span_zero ? S_OUT : S_DIV;
                end
                else if (idx_inc == n_keys)
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EASE;
                end
            end
            S_EASE:
            begin
                if (ease_done)
                begin
                    state_next = S_BLEND;
                end
            end
            S_BLEND:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, configuration and playback
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            loop_reg      <= 1'b1;
            speed_reg     <= SPEED_RST;
            clip_reg      <= '0;
            count_reg     <= '0;
            play_reg      <= '0;
            playing_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (paddr[4:2])
                    REG_ENABLE: enable_reg <= pwdata[0];
                    REG_LOOP:   loop_reg   <= pwdata[0];
                    REG_SPEED:  speed_reg  <= pwdata[15:0];
                    REG_CLIP:   clip_reg   <= pwdata[23:0];
                    REG_COUNT:  count_reg  <= pwdata[6:0];
                    default:
                    begin
                    end
                endcase
            end

            // restart: rewind and start play
            if (req_take && req.mode == MODE_RESTART)
            begin
                play_reg    <= '0;
                playing_reg <= 1'b1;
            end

            if (state_reg == S_ADD && !loop_reg)
            begin
                // clamp to the clip and stop at its end
                if (t_sum >= $signed({10'd0, clip_reg}))
                begin
                    play_reg    <= clip_reg;
                    playing_reg <= 1'b0;
                end
                else if (t_sum <= 34'sd0)
                begin
                    play_reg <= '0;
                end
                else
                begin
                    play_reg <= t_sum[23:0];
                end
            end

            if (state_reg == S_MOD && div_done)
            begin
                play_reg <= mod_res;
            end

            if (state_reg == S_OUT && (!res_valid_reg || res_ready))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dt_reg <= req.step_time;
            end
            S_MUL:
            begin
                prod_reg <= $signed({1'b0, dt_reg}) * speed_reg;
            end
            S_ADD:
            begin
                t_reg <= t_sum;
            end
            S_SAMPLE:
            begin
                idx_reg <= '0;
                val_reg <= '0;
            end
            S_KEY:
            begin
                if (state_next == S_KEY)
                begin
                    prev_reg <= key;
                end
                cur_reg  <= key;
                idx_reg  <= idx_inc;
                val_reg  <= key.key_value;
            end
            S_BLEND:
            begin
                val_reg <= prev_reg.key_value + blend_reg[47:16];
            end
            S_EASE:
            begin
                blend_reg <= diff * $signed({1'b0, ease_curve});
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_reg.sample_value  <= val_reg;
                    res_reg.playhead      <= play_reg;
                    res_reg.still_playing <= playing_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // hold the pair around the hit: prev stays the key before, cur the hit key
    // (S_KEY leaves on a hit, so the last write above puts the hit key in cur;
    // prev is rewritten only while the scan continues)

    always_comb
    begin
        case (paddr[4:2])
            REG_ENABLE: prdata = {31'd0, enable_reg};
            REG_LOOP:   prdata = {31'd0, loop_reg};
            REG_SPEED:  prdata = {16'd0, speed_reg};
            REG_CLIP:   prdata = {8'd0, clip_reg};
            REG_COUNT:  prdata = {25'd0, count_reg};
            default:    prdata = '0;
        endcase
    end

    kes_ram #(
        .WIDTH(KW),
        .DEPTH(MAX_KEYS)
    ) u_keys (
        .clk  (clk),
        .we   (key_we),
        .waddr(KAW'(req.key_index)),
        .wdata({req.key_time, req.key_value, req.key_easing}),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    kes_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .done (div_done),
        .quot (div_quot),
        .rem  (div_rem)
    );

    kes_ease #(
        .EASE_TABLE_POINTS(EASE_TABLE_POINTS)
    ) u_ease (
        .clk  (clk),
        .rst_n(rst_n),
        .start(ease_start),
        .alpha(alpha),
        .code (cur_reg.key_easing),
        .done (ease_done),
        .curve(ease_curve)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
endmodule
`default_nettype wire

// ===== tb/tb_keyframe_easing_sampler_unit.sv =====
// Testbench for the keyframe easing sampler: directed and random requests checked against a predictor.
module tb_keyframe_easing_sampler_unit;
    import kes_pkg::*;

    localparam int         N_KEYS        = 64;
    localparam int         EASE_PTS      = 257;
    localparam int         WATCH_LIMIT   = 20000;
    localparam int         SETTLE_CYCLES = 300;
    localparam int         HOLD_CYCLES   = 1500;
    localparam logic [1:0] MODE_IGNORED  = 2'd3;
    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    req_t              req;
    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    keyframe_easing_sampler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Predictor copy of the key store, playhead and registers
    logic [23:0]        key_times  [N_KEYS];
    logic signed [31:0] key_values [N_KEYS];
    logic [2:0]         key_curves [N_KEYS];
    bit                 key_loaded [N_KEYS];
    logic [23:0]        head_pos;
    bit                 head_running;
    bit                 cfg_enable;
    bit                 cfg_loop;
    logic signed [15:0] cfg_speed;
    logic [23:0]        cfg_clip;
    logic [6:0]         cfg_keys;
    logic [16:0]        exp_curve [EASE_PTS];
    logic [16:0]        log_curve [EASE_PTS];

    res_t pending_samples[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int quiet_cycles;
    int mismatches;
    int samples_checked;
    int requests_sent;
    int track_loads;

    // e^x - 1 in Q30 by a truncated power series
    function automatic logic [63:0] expm1_q30(logic [63:0] x);
        logic [63:0] term;
        logic [63:0] acc;
        term = ONE_Q30;
        acc  = 64'd0;
        for (int n = 1; n <= 24; n++)
        begin
            term = ((term * x) >> 30) / 64'(n);
            acc  = acc + term;
        end
        return acc;
    endfunction

    task automatic build_curves();
        logic [63:0] e_m1;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] s;
        e_m1 = expm1_q30(ONE_Q30);
        for (int k = 0; k < EASE_PTS; k++)
        begin
            x = (64'(k) << 30) / 64'(EASE_PTS - 1);
            r = ((expm1_q30(x) << 16) + e_m1 / 64'd2) / e_m1;
            exp_curve[k] = (r > 64'd65536) ? 17'd65536 : r[16:0];
            // ln(y) = 2 atanh((y - 1) / (y + 1))
            y  = ONE_Q30 + ((x * e_m1) >> 30);
            z  = ((y - ONE_Q30) << 30) / (y + ONE_Q30);
            z2 = (z * z) >> 30;
            pw = z;
            s  = 64'd0;
            for (int n = 0; n < 24; n++)
            begin
                s  = s + pw / 64'(2 * n + 1);
                pw = (pw * z2) >> 30;
            end
            r = (64'd2 * s + (64'd1 << 13)) >> 14;
            log_curve[k] = (r > 64'd65536) ? 17'd65536 : r[16:0];
        end
    endtask

    function automatic logic [16:0] curve_lookup(logic [16:0] a, bit use_log);
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] frac;
        logic [16:0] lo;
        logic [16:0] hi;
        p    = 64'(a) * 64'(EASE_PTS - 1);
        idx  = p >> 16;
        frac = p & 64'hFFFF;
        if (idx >= 64'(EASE_PTS - 1))
            return use_log ? log_curve[EASE_PTS - 1] : exp_curve[EASE_PTS - 1];
        lo = use_log ? log_curve[idx] : exp_curve[idx];
        hi = use_log ? log_curve[idx + 1] : exp_curve[idx + 1];
        if (hi < lo)
            return lo;
        return lo + 17'((64'(hi - lo) * frac) >> 16);
    endfunction

    function automatic logic [16:0] eased(logic [16:0] a, logic [2:0] curve);
        logic [63:0] u;
        logic [63:0] sq;
        case (curve)
            EASE_STEP:   return 17'd0;
            EASE_LINEAR: return a;
            EASE_IN:     return 17'((64'(a) * 64'(a)) >> 16);
            EASE_OUT:
            begin
                u = 64'd65536 - 64'(a);
                return 17'(64'd65536 - ((u * u) >> 16));
            end
            EASE_INOUT:
            begin
                if (a < 17'd32768)
                    return 17'((64'd2 * 64'(a) * 64'(a)) >> 16);
                u = 64'd131072 - 64'd2 * 64'(a);
                return 17'(64'd65536 - ((u * u) >> 17));
            end
            EASE_SMOOTH:
            begin
                sq = (64'(a) * 64'(a)) >> 16;
                return 17'((sq * (64'd196608 - 64'd2 * 64'(a))) >> 16);
            end
            EASE_EXP:    return curve_lookup(a, 1'b0);
            default:     return curve_lookup(a, 1'b1);
        endcase
    endfunction

    // Value of the track at time t: find the bracketing keys and blend
    function automatic logic signed [31:0] track_value(logic [23:0] t);
        int          n;
        longint      span;
        longint      num;
        longint      q;
        longint      d;
        logic [16:0] a;
        n = (cfg_keys < N_KEYS) ? int'(cfg_keys) : N_KEYS;
        if (n == 0)
            return 32'sd0;
        if (n == 1 || t <= key_times[0])
            return key_values[0];
        for (int i = 1; i < n; i++)
        begin
            if (t > key_times[i])
                continue;
            span = longint'(key_times[i]) - longint'(key_times[i - 1]);
            if (span <= 0)
                return key_values[i];
            num = longint'(t) - longint'(key_times[i - 1]);
            if (num <= 0)
                a = 17'd0;
            else
            begin
                q = (num * 65536) / span;
                a = (q > 65536) ? 17'd65536 : 17'(q);
            end
            d = longint'(key_values[i]) - longint'(key_values[i - 1]);
            return 32'(longint'(key_values[i - 1])
                       + ((d * longint'(eased(a, key_curves[i]))) >>> 16));
        end
        return key_values[n - 1];
    endfunction

    // Apply one accepted request to the predictor; a tick that runs queues a sample
    task automatic predict_request(req_t r);
        longint delta;
        longint t;
        longint len;
        res_t   s;
        case (r.mode)
            MODE_WRITE:
            begin
                key_times[r.key_index]  = r.key_time;
                key_values[r.key_index] = r.key_value;
                key_curves[r.key_index] = r.key_easing;
                key_loaded[r.key_index] = 1'b1;
            end
            MODE_RESTART:
            begin
                head_pos     = 24'd0;
                head_running = 1'b1;
            end
            MODE_TICK:
            begin
                if (cfg_enable && head_running && cfg_clip != 24'd0)
                begin
                    delta = (longint'(r.step_time) * longint'(cfg_speed)) >>> 8;
                    t     = longint'(head_pos) + delta;
                    len   = longint'(cfg_clip);
                    if (cfg_loop)
                    begin
                        t = t % len;
                        if (t < 0)
                            t = t + len;
                    end
                    else
                    begin
                        if (t <= 0)
                            t = 0;
                        if (t >= len)
                        begin
                            t = len;
                            head_running = 1'b0;
                        end
                    end
                    head_pos        = 24'(t);
                    s.sample_value  = track_value(head_pos);
                    s.playhead      = head_pos;
                    s.still_playing = head_running;
                    pending_samples.push_back(s);
                end
            end
            default: ;
        endcase
    endtask

    function automatic int loaded_prefix();
        for (int i = 0; i < N_KEYS; i++)
            if (!key_loaded[i])
                return i;
        return N_KEYS;
    endfunction

    // Result side: check each sample, drive ready with random stalls, run the watchdog
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                samples_checked++;
                if (pending_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected sample: value %0d playhead %h playing %0b",
                                 res.sample_value, res.playhead, res.still_playing);
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (res.sample_value !== want.sample_value || res.playhead !== want.playhead
                        || res.still_playing !== want.still_playing)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample %0d: expected %0d/%h/%0b, got %0d/%h/%0b",
                                     samples_checked, want.sample_value, want.playhead,
                                     want.still_playing, res.sample_value, res.playhead,
                                     res.still_playing);
                    end
                end
            end
            if ((req_valid && req_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCH_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCH_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
        // Hold ready low through a requested back-pressure stretch
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one request, idling first at random; valid stays up until it is taken
    task automatic send_request(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        predict_request(r);
        if (r.mode != MODE_IGNORED)
            requests_sent++;
    endtask

    // Drop valid, wait for every sample, then let a running tick finish
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ENABLE: cfg_enable = value[0];
            REG_LOOP:   cfg_loop   = value[0];
            REG_SPEED:  cfg_speed  = value[15:0];
            REG_CLIP:   cfg_clip   = value[23:0];
            REG_COUNT:  cfg_keys   = value[6:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic req_t make_request(logic [1:0] mode, logic [5:0] slot, logic [23:0] kt,
                                          logic [31:0] kv, logic [2:0] curve,
                                          logic [23:0] dt);
        req_t r;
        r.mode       = mode;
        r.key_index  = slot;
        r.key_time   = kt;
        r.key_value  = kv;
        r.key_easing = curve;
        r.step_time  = dt;
        return r;
    endfunction

    function automatic req_t noise_request(logic [1:0] mode);
        return make_request(mode, 6'($urandom), 24'($urandom), $urandom, 3'($urandom),
                            24'($urandom));
    endfunction

    function automatic req_t tick(logic [23:0] dt);
        return make_request(MODE_TICK, 6'($urandom), 24'($urandom), $urandom, 3'($urandom), dt);
    endfunction

    // Directed: empty and single-key tracks, a track with every curve and a zero span, speed extremes
    task automatic test_directed();
        send_request(make_request(MODE_RESTART, 6'd0, 24'd0, 32'd0, EASE_STEP, 24'd0));
        send_request(tick(24'h001000));          // disabled: no sample
        settle();
        write_register(REG_ENABLE, 32'd1);
        write_register(REG_CLIP, 32'h030000);
        send_request(tick(24'h001000));          // empty track gives zero
        for (int j = 0; j < 8; j++)
        begin
            // slot 3 shares slot 2's time: a zero-length span
            send_request(make_request(MODE_WRITE, 6'(j), 24'((j == 3 ? 2 : j) * 24'h6000),
                                      (j % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF - j * 32'h1000,
                                      3'(j), 24'd0));
        end
        settle();
        write_register(REG_COUNT, 32'd1);
        send_request(tick(24'h002000));          // single key
        settle();
        write_register(REG_COUNT, 32'd8);
        for (int j = 0; j < 8; j++)
            send_request(tick(24'h005000));      // walk the spans and run past the last key
        send_request(noise_request(MODE_IGNORED));
        send_request(make_request(MODE_WRITE, 6'd63, 24'hFFFFFF, 32'h8000_0000, EASE_LOG,
                                  24'hFFFFFF));
        settle();
        write_register(REG_LOOP, 32'd0);
        write_register(REG_SPEED, 32'h8000);
        send_request(tick(24'h000100));          // steps backwards
        settle();
        write_register(REG_SPEED, 32'h7FFF);
        send_request(tick(24'hFFFFFF));          // clamps at the end, stops
        send_request(tick(24'h000100));          // stopped: no sample
        send_request(make_request(MODE_RESTART, 6'd0, 24'd0, 32'd0, EASE_STEP, 24'd0));
        send_request(tick(24'd0));
        settle();
    endtask

    // Random batches: new settings, a sorted track, ticks, and some noise
    task automatic test_random(int target, int sp, int rp, bit squeeze);
        int          sent0;
        int          k;
        int          ticks;
        int          pick;
        logic [23:0] gap;
        logic [63:0] kt;
        logic [31:0] v;
        bit          held;
        sent0 = requests_sent;
        held  = 1'b0;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        while (requests_sent - sent0 < target)
        begin
            settle();
            pick = $urandom_range(19);
            write_register(REG_CLIP, pick == 0 ? 32'd0 : pick == 1 ? 32'd1 :
                           pick == 2 ? 32'hFFFFFF : $urandom_range(32'h4000, 32'h0A0000));
            pick = $urandom_range(19);
            if (pick == 0)
                v = 32'h8000;
            else if (pick == 1)
                v = 32'h7FFF;
            else if (pick == 2)
                v = 32'd0;
            else if (pick < 6)
                v = $urandom_range(32'hFFFF);
            else
            begin
                v = $urandom_range(64, 768);
                if ($urandom_range(99) < 15)
                    v = (-v) & 32'hFFFF;
            end
            write_register(REG_SPEED, v);
            write_register(REG_LOOP, $urandom_range(1));
            write_register(REG_ENABLE, $urandom_range(99) < 90);
            // load a sorted track into the low slots
            k   = ($urandom_range(11) == 0) ? N_KEYS : $urandom_range(2, 12);
            gap = (cfg_clip == 24'd0) ? 24'h1000 : cfg_clip / 24'(k);
            kt  = 64'd0;
            for (int j = 0; j < k; j++)
            begin
                if (j == 0 || $urandom_range(9) != 0)
                    kt = 64'(j) * 64'(gap) + 64'($urandom_range(gap / 2));
                send_request(make_request(MODE_WRITE, 6'(j), kt[23:0], $urandom,
                                          3'($urandom), 24'($urandom)));
            end
            track_loads++;
            settle();
            pick = $urandom_range(9);
            if (pick == 0)
                write_register(REG_COUNT, $urandom_range(1));
            else if (loaded_prefix() == N_KEYS && pick < 4)
                write_register(REG_COUNT, $urandom_range(N_KEYS + 1, 127));
            else
                write_register(REG_COUNT, k);
            send_request(make_request(MODE_RESTART, 6'($urandom), 24'($urandom), $urandom,
                                      3'($urandom), 24'($urandom)));
            ticks = $urandom_range(20, 40);
            for (int j = 0; j < ticks; j++)
            begin
                if (squeeze && !held && requests_sent - sent0 > target / 2)
                begin
                    // long back-pressure while requests keep coming
                    hold_left = HOLD_CYCLES;
                    held      = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 5)
                    send_request(noise_request(MODE_IGNORED));
                else if (pick < 10)
                    send_request(noise_request(MODE_RESTART));
                else if (pick < 15)
                    send_request(noise_request(MODE_WRITE));
                else if (pick < 30)
                    send_request(tick(24'($urandom)));
                else
                    send_request(tick(24'($urandom_range(cfg_clip / 6 + 1))));
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        res_ready <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= 32'd0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        mismatches      = 0;
        samples_checked = 0;
        requests_sent   = 0;
        track_loads     = 0;
        // reset values of the registers and playhead
        head_pos     = 24'd0;
        head_running = 1'b0;
        cfg_enable   = 1'b0;
        cfg_loop     = 1'b1;
        cfg_speed    = SPEED_RST;
        cfg_clip     = 24'd0;
        cfg_keys     = 7'd0;
        for (int i = 0; i < N_KEYS; i++)
            key_loaded[i] = 1'b0;
        build_curves();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_random(510, 35, 83, 1'b0);
        test_random(510, 83, 35, 1'b0);
        test_random(510, 0, 0, 1'b1);

        $display("%0d requests, %0d samples checked, %0d tracks loaded", requests_sent,
                 samples_checked, track_loads);
        $display("curves, wrap, clamp, speed and clip extremes covered; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
